@@ sv/life_grid_generation_engine_assert.svh @@
// Assertion macros shared by the life grid generation engine RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef LIFE_GRID_GENERATION_ENGINE_ASSERT_SVH
`define LIFE_GRID_GENERATION_ENGINE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LGGE_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LGGE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/lgge_pkg.sv @@
// Constants and helper functions of the life grid generation engine.
// Depends on nothing; used by life_grid_generation_engine.
package lgge_pkg;

	// Command codes carried in the input word.
	localparam logic [1:0] CMD_WRITE   = 2'd0;
	localparam logic [1:0] CMD_READ    = 2'd1;
	localparam logic [1:0] CMD_ADVANCE = 2'd2;

	// Configuration register file.
	localparam int CFG_W     = 7;
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;
	localparam logic [CFG_W-1:0] CFG_DIM_RESET = 7'd64;
	localparam int MIN_DIM = 3;

	// Standard rule: birth on three neighbors, survival on two or three.
	function automatic logic life_rule(input logic [7:0] nb, input logic alive);
		logic [3:0] cnt;
		cnt = 4'd0;
		for (int i = 0; i < 8; i++) begin
			cnt = cnt + {3'd0, nb[i]};
		end
		return (cnt == 4'd3) || (alive && (cnt == 4'd2));
	endfunction

endpackage

@@ sv/life_grid_generation_engine.sv @@
// Conway life engine on a toroidal grid of up to MAX_WIDTH by MAX_HEIGHT cells.
// Depends on lgge_pkg, lgge_ram and life_grid_generation_engine_assert.svh.
//
// The grid lives in one RAM holding one row of MAX_WIDTH cells per entry, and only the
// top-left grid_width by grid_height region (each clamped to 3..MAX) takes part in a
// generation; cells outside it keep their values. After reset the block sweeps the RAM
// to all dead, one row a cycle, and holds in_stall high meanwhile; configuration writes
// are taken during the sweep. A write or read word goes through a row read, a row update
// and a result step; a word with the unused command code goes straight to the result
// step. An advance word first loads the last and first grid rows, then sweeps the rows:
// the row RAM read port delivers one row a cycle, and all cells of a row are updated in
// parallel lanes from three row registers. One result word is produced per input word,
// held in an output register so the next input word can be taken while it waits.
`include "life_grid_generation_engine_assert.svh"

module life_grid_generation_engine #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64,
	localparam int XW = $clog2(MAX_WIDTH),
	localparam int YW = $clog2(MAX_HEIGHT)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// Configuration write port
	input  logic                           cfg_wr_en,
	input  logic [lgge_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lgge_pkg::CFG_W-1:0]     cfg_data,
	// Input channel
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [1:0]                     command,
	input  logic [XW-1:0]                  cell_x,
	input  logic [YW-1:0]                  cell_y,
	input  logic                           cell_value,
	// Output channel
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           read_value,
	output logic [1:0]                     completed_command
);

	localparam int WCW = $clog2(MAX_WIDTH + 1);
	localparam int HCW = $clog2(MAX_HEIGHT + 1);
	localparam int WXW = (WCW > lgge_pkg::CFG_W) ? WCW : lgge_pkg::CFG_W;
	localparam int HXW = (HCW > lgge_pkg::CFG_W) ? HCW : lgge_pkg::CFG_W;

	typedef enum logic [6:0] {
		S_CLEAR   = 7'b0000001,
		S_IDLE    = 7'b0000010,
		S_ACCESS  = 7'b0000100,
		S_GEN_TOP = 7'b0001000,
		S_GEN_MID = 7'b0010000,
		S_GEN_ROW = 7'b0100000,
		S_FINISH  = 7'b1000000
	} state_t;

	state_t                    state_q;
	logic [YW-1:0]             row_q;
	logic [lgge_pkg::CFG_W-1:0] grid_width_q;
	logic [lgge_pkg::CFG_W-1:0] grid_height_q;
	logic                      out_valid_q;
	logic                      out_read_value_q;
	logic [1:0]                out_command_q;

	logic [1:0]                cmd_q;
	logic [XW-1:0]             x_q;
	logic [YW-1:0]             y_q;
	logic                      value_q;
	logic                      inside_q;
	logic                      rv_q;
	logic [MAX_WIDTH-1:0]      top_q;
	logic [MAX_WIDTH-1:0]      mid_q;
	logic [MAX_WIDTH-1:0]      row0_q;

	logic [WCW-1:0]            w_eff;
	logic [HCW-1:0]            h_eff;
	logic [XW-1:0]             w_last;
	logic [YW-1:0]             h_last;
	logic                      in_accept;
	logic                      in_inside;
	logic                      out_free;
	logic                      gen_last_row;
	logic [YW:0]               row_p2;
	logic [MAX_WIDTH-1:0]      bot_row;
	logic [MAX_WIDTH-1:0]      next_row;
	logic [MAX_WIDTH-1:0]      acc_row;

	logic                      ram_wr_en;
	logic [YW-1:0]             ram_wr_addr;
	logic [MAX_WIDTH-1:0]      ram_wr_data;
	logic                      ram_rd_en;
	logic [YW-1:0]             ram_rd_addr;
	logic [MAX_WIDTH-1:0]      ram_rd_data;

	// Effective grid size, clamped to the supported range.
	always_comb begin
		if (grid_width_q < lgge_pkg::CFG_W'(lgge_pkg::MIN_DIM)) begin
			w_eff = WCW'(lgge_pkg::MIN_DIM);
		end else if (WXW'(grid_width_q) > WXW'(MAX_WIDTH)) begin
			w_eff = WCW'(MAX_WIDTH);
		end else begin
			w_eff = WCW'(grid_width_q);
		end
		if (grid_height_q < lgge_pkg::CFG_W'(lgge_pkg::MIN_DIM)) begin
			h_eff = HCW'(lgge_pkg::MIN_DIM);
		end else if (HXW'(grid_height_q) > HXW'(MAX_HEIGHT)) begin
			h_eff = HCW'(MAX_HEIGHT);
		end else begin
			h_eff = HCW'(grid_height_q);
		end
	end

	assign w_last = XW'(w_eff - WCW'(1));
	assign h_last = YW'(h_eff - HCW'(1));

	// Input handshake and bounds check of the addressed cell.
	assign in_stall  = (state_q != S_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign in_inside = (WCW'(cell_x) < w_eff) && (HCW'(cell_y) < h_eff);
	assign out_free  = !out_valid_q || !out_stall;

	// Generation sweep: the row below wraps to the saved copy of row zero on the last row.
	assign gen_last_row = (row_q == h_last);
	assign row_p2       = {1'b0, row_q} + (YW + 1)'(2);
	assign bot_row      = gen_last_row ? row0_q : ram_rd_data;

	// One lane per column computes the next value of that cell.
	for (genvar gx = 0; gx < MAX_WIDTH; gx++) begin : g_lane
		logic lt, lm, lb, rt, rm, rb;
		logic [7:0] nb;

		if (gx == 0) begin : g_left_wrap
			assign lt = top_q[w_last];
			assign lm = mid_q[w_last];
			assign lb = bot_row[w_last];
		end else begin : g_left
			assign lt = top_q[gx-1];
			assign lm = mid_q[gx-1];
			assign lb = bot_row[gx-1];
		end

		if (gx == MAX_WIDTH - 1) begin : g_right_wrap
			assign rt = top_q[0];
			assign rm = mid_q[0];
			assign rb = bot_row[0];
		end else begin : g_right
			logic is_last;

			assign is_last = (w_last == XW'(gx));
			assign rt = is_last ? top_q[0] : top_q[gx+1];
			assign rm = is_last ? mid_q[0] : mid_q[gx+1];
			assign rb = is_last ? bot_row[0] : bot_row[gx+1];
		end

		assign nb = {lt, top_q[gx], rt, lm, rm, lb, bot_row[gx], rb};
		assign next_row[gx] = (XW'(gx) <= w_last) ?
			lgge_pkg::life_rule(nb, mid_q[gx]) : mid_q[gx];
	end

	// Row image for a single-cell write.
	always_comb begin
		acc_row = ram_rd_data;
		acc_row[x_q] = value_q;
	end

	// RAM port control per state.
	always_comb begin
		ram_rd_en   = 1'b0;
		ram_rd_addr = '0;
		ram_wr_en   = 1'b0;
		ram_wr_addr = row_q;
		ram_wr_data = next_row;
		unique case (state_q)
			S_CLEAR: begin
				ram_wr_en   = 1'b1;
				ram_wr_data = '0;
			end
			S_IDLE: begin
				ram_rd_en = in_accept;
				if (command == lgge_pkg::CMD_ADVANCE) begin
					ram_rd_addr = h_last;
				end else if (in_inside) begin
					ram_rd_addr = cell_y;
				end
			end
			S_ACCESS: begin
				ram_wr_en   = (cmd_q == lgge_pkg::CMD_WRITE) && inside_q;
				ram_wr_addr = y_q;
				ram_wr_data = acc_row;
			end
			S_GEN_TOP: begin
				ram_rd_en = 1'b1;
			end
			S_GEN_MID: begin
				ram_rd_en   = 1'b1;
				ram_rd_addr = YW'(1);
			end
			S_GEN_ROW: begin
				ram_wr_en   = 1'b1;
				ram_rd_en   = (row_p2 < (YW + 1)'(h_eff));
				ram_rd_addr = row_p2[YW-1:0];
			end
			S_FINISH: begin
			end
			default: begin
			end
		endcase
	end

	lgge_ram #(
		.WIDTH (MAX_WIDTH),
		.DEPTH (MAX_HEIGHT)
	) u_grid_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= lgge_pkg::CFG_DIM_RESET;
			grid_height_q <= lgge_pkg::CFG_DIM_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				lgge_pkg::REG_GRID_WIDTH:  grid_width_q  <= cfg_data;
				lgge_pkg::REG_GRID_HEIGHT: grid_height_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Sequencer and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			row_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// A finished word loads the output register as the old one leaves.
			if (state_q == S_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					row_q <= row_q + YW'(1);
					if (row_q == YW'(MAX_HEIGHT - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_accept) begin
						if (command == lgge_pkg::CMD_WRITE || command == lgge_pkg::CMD_READ) begin
							state_q <= S_ACCESS;
						end else if (command == lgge_pkg::CMD_ADVANCE) begin
							state_q <= S_GEN_TOP;
						end else begin
							state_q <= S_FINISH;
						end
					end
				end
				S_ACCESS: begin
					state_q <= S_FINISH;
				end
				S_GEN_TOP: begin
					state_q <= S_GEN_MID;
				end
				S_GEN_MID: begin
					row_q   <= '0;
					state_q <= S_GEN_ROW;
				end
				S_GEN_ROW: begin
					row_q <= row_q + YW'(1);
					if (gen_last_row) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Data path registers: the accepted word, row buffers and the result word.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			cmd_q    <= command;
			x_q      <= cell_x;
			y_q      <= cell_y;
			value_q  <= cell_value;
			inside_q <= in_inside;
			rv_q     <= 1'b0;
		end
		if (state_q == S_ACCESS) begin
			rv_q <= (cmd_q == lgge_pkg::CMD_READ) && inside_q && ram_rd_data[x_q];
		end
		if (state_q == S_GEN_TOP) begin
			top_q <= ram_rd_data;
		end
		if (state_q == S_GEN_MID) begin
			mid_q  <= ram_rd_data;
			row0_q <= ram_rd_data;
		end
		if (state_q == S_GEN_ROW) begin
			top_q <= mid_q;
			mid_q <= bot_row;
		end
		if (state_q == S_FINISH && out_free) begin
			out_read_value_q <= rv_q;
			out_command_q    <= cmd_q;
		end
	end

	assign out_valid         = out_valid_q;
	assign read_value        = out_read_value_q;
	assign completed_command = out_command_q;

	// Consistency checks of the sequencer.
	`LGGE_ASSERT_IMPLY(a_idle_no_write, clk, arst_n, state_q == S_IDLE, !ram_wr_en, "grid RAM written while idle")
	`LGGE_ASSERT_IMPLY(a_out_from_finish, clk, arst_n, $rose(out_valid_q), $past(state_q) == S_FINISH, "result word loaded outside the finish step")
	`LGGE_ASSERT_IMPLY(a_row_in_range, clk, arst_n, state_q == S_GEN_ROW, HCW'(row_q) < h_eff, "generation row beyond grid height")
	`LGGE_ASSERT_NEXT(a_gen_ends, clk, arst_n, state_q == S_GEN_ROW && gen_last_row, state_q == S_FINISH, "generation did not finish after last row")

endmodule

@@ sv/lgge_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing; instanced by life_grid_generation_engine.
module lgge_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
